@@ hw/rtl/nfpi_pkg.sv @@
// ----------------------------------------------------------------------------
// nfpi_pkg
// Shared types and constants for the nearest feature point intensity engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nfpi_pkg;

  // Input request kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Width of the point count register and its reset value.
  localparam int unsigned NUM_W     = 5;
  localparam logic [4:0]  NUM_RESET = 5'd10;

  // The grey level is the largest h with h*h*d2 <= SCALE_SQ (5100 squared).
  localparam logic [24:0] SCALE_SQ = 25'd26010000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  point_index;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
  } in_req_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [7:0]  intensity;
    logic [3:0]  nearest;
  } out_req_t;

  // Pixel coordinates handed from the front to the back.
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
  } pix_t;

  // Point store write from the front.
  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [11:0] x;
    logic [11:0] y;
  } store_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/nfpi_front.sv @@
// ----------------------------------------------------------------------------
// nfpi_front
// Accepts requests, routes loads to the point store and queues pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpi_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  nfpi_pkg::in_req_t    in_data,
  output logic                 in_full,
  input  wire                  back_busy,
  output nfpi_pkg::store_wr_t  store_wr,
  output logic                 q_valid,
  output nfpi_pkg::pix_t       q_head,
  input  wire                  q_pop
);

  nfpi_pkg::pix_t q_mem_r [2];
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           accept, push_pix;

  // A load must wait until every earlier pixel has finished its search.
  always_comb begin
    in_full = (cnt_r == 2'd2) ||
              ((in_data.kind == nfpi_pkg::KIND_LOAD) && ((cnt_r != 2'd0) || back_busy));
  end

  assign accept   = in_push && !in_full;
  assign push_pix = accept && (in_data.kind == nfpi_pkg::KIND_PIXEL);

  // Point store write for load requests.
  always_comb begin
    store_wr.we   = accept && (in_data.kind == nfpi_pkg::KIND_LOAD);
    store_wr.addr = in_data.point_index;
    store_wr.x    = in_data.coord_x;
    store_wr.y    = in_data.coord_y;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    wr_ptr_nxt = wr_ptr_r ^ push_pix;
    cnt_nxt    = cnt_r + {1'b0, push_pix} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_pix) begin
      q_mem_r[wr_ptr_r] <= '{x: in_data.coord_x, y: in_data.coord_y};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nfpi_back.sv @@
// ----------------------------------------------------------------------------
// nfpi_back
// Point store, nearest point search and grey level search for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpi_back #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 12
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [nfpi_pkg::NUM_W-1:0]      num_points,
  input  nfpi_pkg::store_wr_t             store_wr,
  input  wire                             q_valid,
  input  nfpi_pkg::pix_t                  q_head,
  output logic                            q_pop,
  output logic                            busy,
  output logic                            res_valid,
  output nfpi_pkg::out_req_t              res_data,
  input  wire                             res_pop
);

  localparam int CB = COORD_BITS;
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = 2 * CB + 1;
  localparam int PW = 16 + DW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_GSQ  = 3'd4;
  localparam logic [2:0] S_GMUL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [CB-1:0]   mem_x [MAX_POINTS];
  logic [CB-1:0]   mem_y [MAX_POINTS];
  logic [CB-1:0]   rd_x_r, rd_y_r;
  logic [2:0]      state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   last_idx;
  logic [CB-1:0]   px_r, py_r;
  logic [2*CB-1:0] sqx_r, sqy_r;
  logic [DW-1:0]   d2, best_r, best_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  logic [7:0]      h_r, h_nxt, trial;
  logic [2:0]      bit_r, bit_nxt;
  logic [15:0]     tt_r;
  logic [PW-1:0]   prod;
  logic [CB-1:0]   dx, dy;
  logic [6:0]      cnt7;
  logic            res_valid_r;
  nfpi_pkg::out_req_t res_r;

  // Point store: loads write, the search reads one slot a cycle.
  always_ff @(posedge clk) begin
    if (store_wr.we && ({28'd0, store_wr.addr} < 32'(MAX_POINTS))) begin
      mem_x[IW'(store_wr.addr)] <= CB'(store_wr.x);
      mem_y[IW'(store_wr.addr)] <= CB'(store_wr.y);
    end
    rd_x_r <= mem_x[idx_r];
    rd_y_r <= mem_y[idx_r];
  end

  // Number of slots searched, clamped to one and to the store depth.
  always_comb begin
    cnt7 = 7'(num_points);
    if (cnt7 == 7'd0) begin
      cnt7 = 7'd1;
    end
    if (cnt7 > 7'(MAX_POINTS)) begin
      cnt7 = 7'(MAX_POINTS);
    end
    last_idx = IW'(cnt7 - 7'd1);
  end

  assign dx    = (rd_x_r > px_r) ? rd_x_r - px_r : px_r - rd_x_r;
  assign dy    = (rd_y_r > py_r) ? rd_y_r - py_r : py_r - rd_y_r;
  assign d2    = DW'(sqx_r) + DW'(sqy_r);
  assign trial = h_r | (8'd1 << bit_r);
  assign prod  = PW'(tt_r) * PW'(best_r);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  // Search sequencer.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    h_nxt        = h_r;
    bit_nxt      = bit_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          idx_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_SQR;
      S_SQR:  state_nxt = S_CMP;
      S_CMP: begin
        if ((idx_r == '0) || (d2 < best_r)) begin
          best_nxt     = d2;
          best_idx_nxt = idx_r;
        end
        if (idx_r == last_idx) begin
          h_nxt     = 8'd0;
          bit_nxt   = 3'd7;
          state_nxt = S_GSQ;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_GSQ: state_nxt = S_GMUL;
      S_GMUL: begin
        if (prod <= PW'(nfpi_pkg::SCALE_SQ)) begin
          h_nxt = trial;
        end
        if (bit_r == 3'd0) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt   = bit_r - 3'd1;
          state_nxt = S_GSQ;
        end
      end
      S_DONE: begin
        if (!res_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && !res_valid_r) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    h_r        <= h_nxt;
    bit_r      <= bit_nxt;
    sqx_r      <= (2*CB)'(dx) * (2*CB)'(dx);
    sqy_r      <= (2*CB)'(dy) * (2*CB)'(dy);
    tt_r       <= 16'(trial) * 16'(trial);
    if (q_pop) begin
      px_r <= CB'(q_head.x);
      py_r <= CB'(q_head.y);
    end
    if ((state_r == S_DONE) && !res_valid_r) begin
      res_r.out_x     <= 12'(px_r);
      res_r.out_y     <= 12'(py_r);
      res_r.intensity <= h_r;
      res_r.nearest   <= 4'(best_idx_r);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_feature_point_intensity.sv @@
// ----------------------------------------------------------------------------
// nearest_feature_point_intensity
// Cellular noise pixel engine: nearest feature point and its grey level.
// ----------------------------------------------------------------------------
// A pixel waits in the queue, then the back end searches every counted point
// (read, square, compare) and runs the bit-serial grey level search (square
// the trial, multiply and compare, top bit first) before it registers the
// result, one pixel at a time. A new pixel is taken only when the last is done,
// and a finished result waits until the previous one has been popped. Load
// requests wait for pending pixels. Reset is synchronous; the point count
// resets to 10, the point store is left undefined until loaded.
`default_nettype none

module nearest_feature_point_intensity #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 12
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_push,
  input  nfpi_pkg::in_req_t           in_data,
  output logic                        in_full,
  output logic                        out_empty,
  output nfpi_pkg::out_req_t          out_data,
  input  wire                         out_pop,
  input  wire                         cfg_we,
  input  wire  [nfpi_pkg::NUM_W-1:0]  cfg_data
);

  logic [nfpi_pkg::NUM_W-1:0] num_points_r;
  nfpi_pkg::store_wr_t        store_wr;
  nfpi_pkg::pix_t             q_head;
  logic                       q_valid, q_pop, back_busy, res_valid;

  // Point count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= nfpi_pkg::NUM_RESET;
    end else if (cfg_we) begin
      num_points_r <= cfg_data;
    end
  end

  nfpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .back_busy (back_busy),
    .store_wr  (store_wr),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  nfpi_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .num_points (num_points_r),
    .store_wr   (store_wr),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .res_valid  (res_valid),
    .res_data   (out_data),
    .res_pop    (out_pop)
  );

  assign out_empty = !res_valid;

endmodule

`default_nettype wire

@@ hw/rtl/nfpi_checker.sv @@
// ----------------------------------------------------------------------------
// nfpi_checker
// Port level checks for the nearest feature point intensity engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpi_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_empty,
  input wire                out_pop,
  input nfpi_pkg::out_req_t out_data
);

  // The result side comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // A waiting result leaves only when it is popped.
  a_leave_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped without pop");

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind nearest_feature_point_intensity nfpi_checker u_nfpi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
